### rtl/wnf_pkg.sv
`timescale 1ns / 1ps
package wnf_pkg;

    localparam int MAX_LEN = 64;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int BANK_AW = ADDR_W + 1;
    localparam int ELEM_W  = 16;
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int LEN_W   = 7;
    localparam int CNT_W   = 7;
    localparam int SUM_W   = 37;
    localparam int NORM_W  = 20;
    localparam int RAD_W   = 2 * NORM_W;
    localparam int DVD_W   = PROD_W + 2;
    localparam int REM_W   = NORM_W + 2;
    localparam int IT_W    = 6;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_LEN);

    typedef struct packed {
        logic                     bank;
        logic [CNT_W-1:0]         count;
        logic [SUM_W-1:0]         sum;
        logic signed [ELEM_W-1:0] gain;
    } t_desc;

    typedef struct packed {
        logic               en;
        logic [BANK_AW-1:0] addr;
        logic [ELEM_W-1:0]  data;
    } t_wr;

    typedef struct packed {
        logic en;
        logic bank;
    } t_rel;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SQRT,
        BK_RD,
        BK_MUL,
        BK_PREP,
        BK_DIV,
        BK_OUT
    } t_back_state;

endpackage

### rtl/wnf_in_if.sv
`timescale 1ns / 1ps
interface wnf_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [wnf_pkg::ELEM_W-1:0]  elem_value;
    logic signed [wnf_pkg::ELEM_W-1:0]  gain;

    modport source (output valid, elem_value, gain, input ready);
    modport sink   (input valid, elem_value, gain, output ready);
endinterface

### rtl/wnf_out_if.sv
`timescale 1ns / 1ps
interface wnf_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [wnf_pkg::ELEM_W-1:0]  weight_out;
    logic [wnf_pkg::NORM_W-1:0]         norm_out;
    logic                               zero_norm;
    logic                               last;

    modport source (output valid, weight_out, norm_out, zero_norm, last, input ready);
    modport sink   (input valid, weight_out, norm_out, zero_norm, last, output ready);
endinterface

### rtl/wnf_store.sv
`timescale 1ns / 1ps
module wnf_store (
    input  logic                             i_clk,
    input  wnf_pkg::t_wr                     i_wr,
    input  logic                             i_rd_en,
    input  logic [wnf_pkg::BANK_AW-1:0]      i_rd_addr,
    output logic [wnf_pkg::ELEM_W-1:0]       o_rd_data
);
    logic [wnf_pkg::ELEM_W-1:0] r_mem [0:2*wnf_pkg::MAX_LEN-1];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule

### rtl/wnf_queue.sv
`timescale 1ns / 1ps
module wnf_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wnf_pkg::t_desc i_desc,
    input  logic           i_pop,
    output logic           o_empty,
    output logic           o_full,
    output wnf_pkg::t_desc o_desc
);
    wnf_pkg::t_desc r_slot [0:1];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           do_push, do_pop;

    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_desc  = r_slot[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wp] <= i_desc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= !r_wp;
            if (do_pop)  r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end
endmodule

### rtl/wnf_front.sv
`timescale 1ns / 1ps
module wnf_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [wnf_pkg::LEN_W-1:0]     i_cfg_wdata,
    wnf_in_if.sink                        i_elem,
    input  wnf_pkg::t_rel                 i_rel,
    output wnf_pkg::t_wr                  o_wr,
    output logic                          o_push,
    output wnf_pkg::t_desc                o_desc
);
    logic [wnf_pkg::LEN_W-1:0] r_len;
    logic [wnf_pkg::CNT_W-1:0] r_count;
    logic [wnf_pkg::SUM_W-1:0] r_sum;
    logic                      r_bank;
    logic [1:0]                r_busy;

    logic [wnf_pkg::CNT_W-1:0]         eff_len, cnt_inc;
    logic signed [wnf_pkg::PROD_W-1:0] sq;
    logic [wnf_pkg::SUM_W-1:0]         sum_inc;
    logic                              accept, complete;

    always_comb begin
        if (r_len == '0) begin
            eff_len = wnf_pkg::CNT_W'(1);
        end else if (r_len > wnf_pkg::LEN_W'(wnf_pkg::MAX_LEN)) begin
            eff_len = wnf_pkg::CNT_W'(wnf_pkg::MAX_LEN);
        end else begin
            eff_len = r_len;
        end
    end

    assign i_elem.ready = !r_busy[r_bank];
    assign accept   = i_elem.valid && i_elem.ready;
    assign cnt_inc  = r_count + 1'b1;
    assign complete = (cnt_inc >= eff_len);
    assign sq       = i_elem.elem_value * i_elem.elem_value;
    assign sum_inc  = r_sum + wnf_pkg::SUM_W'(unsigned'(sq));

    assign o_wr.en   = accept;
    assign o_wr.addr = {r_bank, r_count[wnf_pkg::ADDR_W-1:0]};
    assign o_wr.data = i_elem.elem_value;

    assign o_push      = accept && complete;
    assign o_desc.bank  = r_bank;
    assign o_desc.count = cnt_inc;
    assign o_desc.sum   = sum_inc;
    assign o_desc.gain  = i_elem.gain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len   <= wnf_pkg::LEN_RESET;
            r_count <= '0;
            r_sum   <= '0;
            r_bank  <= 1'b0;
            r_busy  <= 2'b00;
        end else begin
            if (i_cfg_we) r_len <= i_cfg_wdata;
            if (i_rel.en) r_busy[i_rel.bank] <= 1'b0;
            if (accept) begin
                if (complete) begin
                    r_count        <= '0;
                    r_sum          <= '0;
                    r_busy[r_bank] <= 1'b1;
                    r_bank         <= !r_bank;
                end else begin
                    r_count <= cnt_inc;
                    r_sum   <= sum_inc;
                end
            end
        end
    end
endmodule

### rtl/wnf_back.sv
`timescale 1ns / 1ps
module wnf_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_q_empty,
    input  wnf_pkg::t_desc                 i_desc,
    output logic                           o_pop,
    output logic                           o_rd_en,
    output logic [wnf_pkg::BANK_AW-1:0]    o_rd_addr,
    input  logic [wnf_pkg::ELEM_W-1:0]     i_rd_data,
    output wnf_pkg::t_rel                  o_rel,
    wnf_out_if.source                      o_res
);
    localparam int ELEM_W = wnf_pkg::ELEM_W;
    localparam logic [wnf_pkg::DVD_W-1:0] POS_MAX = wnf_pkg::DVD_W'((1 << (ELEM_W - 1)) - 1);
    localparam logic [wnf_pkg::DVD_W-1:0] NEG_MAX = wnf_pkg::DVD_W'(1 << (ELEM_W - 1));

    wnf_pkg::t_back_state r_state, n_state;
    wnf_pkg::t_desc       r_desc;

    logic [wnf_pkg::RAD_W-1:0]         r_x;
    logic [wnf_pkg::NORM_W-1:0]        r_root;
    logic [wnf_pkg::REM_W-1:0]         r_rem;
    logic [wnf_pkg::IT_W-1:0]          r_it;
    logic [wnf_pkg::CNT_W-1:0]         r_k;
    logic signed [wnf_pkg::PROD_W-1:0] r_prod;
    logic [wnf_pkg::DVD_W-1:0]         r_dvd;
    logic                              r_neg;

    logic                              r_ovalid;
    logic signed [ELEM_W-1:0]          r_w;
    logic [wnf_pkg::NORM_W-1:0]        r_norm;
    logic                              r_zero, r_last;

    logic [wnf_pkg::REM_W+1:0]         s_rem, s_trial;
    logic [wnf_pkg::REM_W-1:0]         d_rem, d_div;
    logic [wnf_pkg::PROD_W-1:0]        pm;
    logic signed [ELEM_W-1:0]          w_sat;
    logic                              out_free, is_last, zero;

    assign out_free = !r_ovalid || o_res.ready;
    assign is_last  = ((r_k + 1'b1) == r_desc.count);
    assign zero     = (r_root == '0);

    // one result bit of the square root per cycle
    assign s_rem   = {r_rem, r_x[wnf_pkg::RAD_W-1 -: 2]};
    assign s_trial = {2'b00, r_root, 2'b01};
    // restoring divide by 2*norm, quotient shifts into r_dvd
    assign d_rem   = {r_rem[wnf_pkg::REM_W-2:0], r_dvd[wnf_pkg::DVD_W-1]};
    assign d_div   = {1'b0, r_root, 1'b0};
    assign pm      = r_prod[wnf_pkg::PROD_W-1] ? unsigned'(-r_prod) : unsigned'(r_prod);

    always_comb begin
        if (zero) begin
            w_sat = '0;
        end else if (r_neg) begin
            w_sat = (r_dvd > NEG_MAX) ? ELEM_W'(NEG_MAX) : ELEM_W'(-r_dvd);
        end else begin
            w_sat = (r_dvd > POS_MAX) ? ELEM_W'(POS_MAX) : ELEM_W'(r_dvd);
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            wnf_pkg::BK_IDLE: if (!i_q_empty) n_state = wnf_pkg::BK_SQRT;
            wnf_pkg::BK_SQRT: if (r_it == '0) n_state = wnf_pkg::BK_RD;
            wnf_pkg::BK_RD:   n_state = wnf_pkg::BK_MUL;
            wnf_pkg::BK_MUL:  n_state = zero ? wnf_pkg::BK_OUT : wnf_pkg::BK_PREP;
            wnf_pkg::BK_PREP: n_state = wnf_pkg::BK_DIV;
            wnf_pkg::BK_DIV:  if (r_it == '0) n_state = wnf_pkg::BK_OUT;
            wnf_pkg::BK_OUT: begin
                if (out_free) n_state = is_last ? wnf_pkg::BK_IDLE : wnf_pkg::BK_RD;
            end
            default:          n_state = wnf_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop     = 1'b0;
        o_rd_en   = 1'b0;
        o_rel.en  = 1'b0;
        o_rel.bank = r_desc.bank;
        o_rd_addr = {r_desc.bank, r_k[wnf_pkg::ADDR_W-1:0]};
        case (r_state)
            wnf_pkg::BK_IDLE: o_pop = !i_q_empty;
            wnf_pkg::BK_RD:   o_rd_en = 1'b1;
            wnf_pkg::BK_OUT:  o_rel.en = out_free && is_last;
            default:          o_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= wnf_pkg::BK_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == wnf_pkg::BK_OUT && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            wnf_pkg::BK_IDLE: begin
                r_desc <= i_desc;
                r_x    <= wnf_pkg::RAD_W'({i_desc.sum, 2'b00});
                r_root <= '0;
                r_rem  <= '0;
                r_it   <= wnf_pkg::IT_W'(wnf_pkg::NORM_W - 1);
                r_k    <= '0;
            end
            wnf_pkg::BK_SQRT: begin
                r_x <= r_x << 2;
                r_it <= r_it - 1'b1;
                if (s_rem >= s_trial) begin
                    r_rem  <= wnf_pkg::REM_W'(s_rem - s_trial);
                    r_root <= {r_root[wnf_pkg::NORM_W-2:0], 1'b1};
                end else begin
                    r_rem  <= wnf_pkg::REM_W'(s_rem);
                    r_root <= {r_root[wnf_pkg::NORM_W-2:0], 1'b0};
                end
            end
            wnf_pkg::BK_MUL: begin
                r_prod <= r_desc.gain * signed'(i_rd_data);
            end
            wnf_pkg::BK_PREP: begin
                r_neg <= r_prod[wnf_pkg::PROD_W-1];
                r_dvd <= {pm, 2'b00} + wnf_pkg::DVD_W'(r_root);
                r_rem <= '0;
                r_it  <= wnf_pkg::IT_W'(wnf_pkg::DVD_W - 1);
            end
            wnf_pkg::BK_DIV: begin
                r_it <= r_it - 1'b1;
                if (d_rem >= d_div) begin
                    r_rem <= d_rem - d_div;
                    r_dvd <= {r_dvd[wnf_pkg::DVD_W-2:0], 1'b1};
                end else begin
                    r_rem <= d_rem;
                    r_dvd <= {r_dvd[wnf_pkg::DVD_W-2:0], 1'b0};
                end
            end
            wnf_pkg::BK_OUT: begin
                if (out_free) begin
                    r_w    <= w_sat;
                    r_norm <= r_root;
                    r_zero <= zero;
                    r_last <= is_last;
                    r_k    <= r_k + 1'b1;
                end
            end
            default: r_it <= r_it;
        endcase
    end

    // norm is held with the word, as the root is rebuilt for the next vector
    assign o_res.valid      = r_ovalid;
    assign o_res.weight_out = r_w;
    assign o_res.norm_out   = r_norm;
    assign o_res.zero_norm  = r_zero;
    assign o_res.last       = r_last;
endmodule

### rtl/weight_norm_forward_core.sv
`timescale 1ns / 1ps
// Loading: one element word per cycle, while the input is ready, into one of two store banks.
// Draining: per vector, take the descriptor and build the square root of the sum;
// per result: store read, multiply, set-up, 34-step restoring divide, output load;
// just read, multiply, output load at zero norm. The divider sets the result rate.
// A vector loads while the previous one drains; input stalls when both banks are held.
// Reset (i_rst_n low, synchronous) clears counts, sums, queue and output valid.
module weight_norm_forward_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [wnf_pkg::LEN_W-1:0] i_cfg_wdata,
    wnf_in_if.sink                    i_elem,
    wnf_out_if.source                 o_res
);
    wnf_pkg::t_wr   wr;
    wnf_pkg::t_rel  rel;
    wnf_pkg::t_desc push_desc, head_desc;
    logic           push, pop, q_empty, q_full, rd_en;
    logic [wnf_pkg::BANK_AW-1:0] rd_addr;
    logic [wnf_pkg::ELEM_W-1:0]  rd_data;

    wnf_front u_front (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_wdata,
        .i_elem (i_elem), .i_rel (rel), .o_wr (wr),
        .o_push (push), .o_desc (push_desc)
    );

    wnf_store u_store (
        .i_clk, .i_wr (wr), .i_rd_en (rd_en),
        .i_rd_addr (rd_addr), .o_rd_data (rd_data)
    );

    wnf_queue u_queue (
        .i_clk, .i_rst_n, .i_push (push), .i_desc (push_desc),
        .i_pop (pop), .o_empty (q_empty), .o_full (q_full), .o_desc (head_desc)
    );

    wnf_back u_back (
        .i_clk, .i_rst_n, .i_q_empty (q_empty), .i_desc (head_desc),
        .o_pop (pop), .o_rd_en (rd_en), .o_rd_addr (rd_addr),
        .i_rd_data (rd_data), .o_rel (rel), .o_res (o_res)
    );

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(push && q_full)) else $error("descriptor queue overflow");

    a_zero_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.zero_norm |-> o_res.weight_out == '0)
        else $error("zero norm with nonzero weight");

    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> o_res.zero_norm == (o_res.norm_out == '0))
        else $error("zero norm flag mismatch");

    a_pop_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_empty) else $error("pop from empty queue");
endmodule
